/* design/elsa_pkg.sv */
// ----------------------------------------------------------------------------
// Exposure loss scatter accumulator package
// Shared types, field widths, command codes and default sizes.
// ----------------------------------------------------------------------------
package elsa_pkg;

  localparam int ExposuresDef = 4096;
  localparam int NodesDef     = 1024;
  localparam int Perils       = 16;

  localparam int CmdW    = 2;
  localparam int IdW     = 12;
  localparam int NodeW   = 10;
  localparam int ValueW  = 32;
  localparam int PerilW  = 4;
  localparam int RatioW  = 16;
  localparam int LimitW  = 13;
  localparam int LossW   = 32;
  localparam int AccW    = 48;
  localparam int ProdW   = ValueW + RatioW;
  localparam int FracW   = 15;

  localparam logic [CmdW-1:0] CmdWrite = 2'd0;
  localparam logic [CmdW-1:0] CmdAdd   = 2'd1;
  localparam logic [CmdW-1:0] CmdRead  = 2'd2;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [IdW-1:0]    exposure_id;
    logic [NodeW-1:0]  node_index;
    logic              node_present;
    logic [ValueW-1:0] exposure_value;
    logic [PerilW-1:0] peril;
    logic [RatioW-1:0] loss_ratio;
    logic              clear_after_read;
    logic              batch_end;
  } elsa_item_t;

  typedef struct packed {
    logic              entry_valid;
    logic              mapped_flag;
    logic [NodeW-1:0]  mapped_node;
    logic [LossW-1:0]  exposure_loss;
    logic [AccW-1:0]   node_loss_total;
    logic [AccW-1:0]   node_value_total;
    logic              overflow_flag;
    logic              batch_done;
  } elsa_result_t;

  typedef struct packed {
    logic              mapped;
    logic [NodeW-1:0]  node;
    logic [ValueW-1:0] value;
    logic [PerilW-1:0] peril;
  } elsa_entry_t;

  typedef struct packed {
    logic [AccW-1:0] loss_total;
    logic [AccW-1:0] value_total;
  } elsa_acc_t;

  localparam int EntryW = $bits(elsa_entry_t);
  localparam int AccEntryW = $bits(elsa_acc_t);

endpackage

/* design/elsa_stream_if.sv */
// ----------------------------------------------------------------------------
// Exposure loss scatter accumulator stream interface
// Valid/ready channel that moves one word of type T per handshake.
// ----------------------------------------------------------------------------
interface elsa_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/elsa_ram.sv */
// ----------------------------------------------------------------------------
// Exposure loss scatter accumulator RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module elsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/elsa_init.sv */
// ----------------------------------------------------------------------------
// Exposure loss scatter accumulator clearing sweep
// Steps an address through every entry once after reset.
// ----------------------------------------------------------------------------
module elsa_init #(
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  output logic             busy_o,
  output logic [AddrW-1:0] addr_o
);

  logic             busy_q, busy_d;
  logic [AddrW-1:0] cnt_q, cnt_d;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (busy_q) begin
      if (cnt_q == AddrW'(Depth - 1)) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  assign busy_o = busy_q;
  assign addr_o = cnt_q;

endmodule

/* design/exposure_loss_scatter_accumulator.sv */
// ----------------------------------------------------------------------------
// Exposure loss scatter accumulator
// Exposure table lookup with loss scaling and per-node saturating totals.
// ----------------------------------------------------------------------------
// After reset the block sweeps both memories to zero, one entry per cycle over
// max(EXPOSURES, NODES) entries (4096 by default), and takes no word until the
// sweep ends; register writes are taken at any time. Words are handled one at
// a time by a sequencer around two registered-read RAMs: a table write goes
// straight to the result, a node read passes a read step and a loss add steps
// through table read, multiply with node read, add and write back, result. The
// result register lets the next word enter while a result waits to be taken.
module exposure_loss_scatter_accumulator #(
  parameter int EXPOSURES = elsa_pkg::ExposuresDef,
  parameter int NODES     = elsa_pkg::NodesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [elsa_pkg::LimitW-1:0] cfg_wdata_i,
  elsa_stream_if.sink                 in_i,
  elsa_stream_if.source               out_o
);
  import elsa_pkg::*;

  localparam int ExpAw    = $clog2(EXPOSURES);
  localparam int NodeAw   = $clog2(NODES);
  localparam int ClrDepth = (EXPOSURES > NODES) ? EXPOSURES : NODES;
  localparam int ClrAw    = $clog2(ClrDepth);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [LimitW-1:0] limit_q;
  elsa_item_t        item_q;
  elsa_item_t        in_w;
  elsa_entry_t       entry_q;
  elsa_entry_t       exp_rd;
  elsa_entry_t       new_entry;
  elsa_acc_t         node_rd;
  elsa_acc_t         node_sum;
  elsa_result_t      res_q, res_d;
  elsa_result_t      out_q;
  logic              out_valid_q;
  logic [ProdW-1:0]  prod_q;
  logic              in_acc;
  logic              out_free;
  logic              load_out;

  logic              clr_busy;
  logic [ClrAw-1:0]  clr_addr;

  logic              exp_we, exp_re;
  logic [ExpAw-1:0]  exp_waddr, exp_raddr;
  logic [EntryW-1:0] exp_wdata, exp_rdata;
  logic              node_we, node_re;
  logic [NodeAw-1:0] node_waddr, node_raddr;
  logic [AccEntryW-1:0] node_wdata, node_rdata;

  logic              id_in_table;
  logic              add_ok;
  logic              node_ok;
  logic              acc_hit;
  logic [LossW:0]    loss_raw;
  logic [LossW-1:0]  loss;
  logic [AccW:0]     loss_sum;
  logic [AccW:0]     value_sum;

  elsa_init #(.Depth(ClrDepth)) u_init (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .busy_o (clr_busy),
    .addr_o (clr_addr)
  );

  elsa_ram #(.Width(EntryW), .Depth(EXPOSURES)) u_exp_ram (
    .clk_i   (clk_i),
    .we_i    (exp_we),
    .waddr_i (exp_waddr),
    .wdata_i (exp_wdata),
    .re_i    (exp_re),
    .raddr_i (exp_raddr),
    .rdata_o (exp_rdata)
  );

  elsa_ram #(.Width(AccEntryW), .Depth(NODES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  assign in_w    = in_i.data;
  assign exp_rd  = exp_rdata;
  assign node_rd = node_rdata;

  assign in_i.ready = (state_q == S_IDLE) && !clr_busy;
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign id_in_table = 32'(in_w.exposure_id) < EXPOSURES;
  assign add_ok      = id_in_table && (13'(in_w.exposure_id) < limit_q);
  assign node_ok     = 32'(in_w.node_index) < NODES;

  always_comb begin
    new_entry.mapped = in_w.node_present && node_ok;
    new_entry.node   = new_entry.mapped ? in_w.node_index : '0;
    new_entry.value  = in_w.exposure_value;
    new_entry.peril  = (32'(in_w.peril) < Perils) ? in_w.peril : '0;
  end

  assign acc_hit  = entry_q.mapped && (32'(entry_q.node) < NODES);
  assign loss_raw = prod_q[ProdW-1:FracW];
  assign loss     = loss_raw[LossW] ? '1 : loss_raw[LossW-1:0];
  assign loss_sum  = {1'b0, node_rd.loss_total} + (AccW + 1)'(loss);
  assign value_sum = {1'b0, node_rd.value_total} + (AccW + 1)'(entry_q.value);

  always_comb begin
    node_sum.loss_total  = loss_sum[AccW] ? '1 : loss_sum[AccW-1:0];
    node_sum.value_total = value_sum[AccW] ? '1 : value_sum[AccW-1:0];
  end

  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    load_out   = 1'b0;
    exp_we     = 1'b0;
    exp_waddr  = ExpAw'(clr_addr);
    exp_wdata  = '0;
    exp_re     = 1'b0;
    exp_raddr  = ExpAw'(in_w.exposure_id);
    node_we    = 1'b0;
    node_waddr = NodeAw'(clr_addr);
    node_wdata = '0;
    node_re    = 1'b0;
    node_raddr = NodeAw'(in_w.node_index);

    if (clr_busy) begin
      exp_we  = 32'(clr_addr) < EXPOSURES;
      node_we = 32'(clr_addr) < NODES;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_d            = '0;
          res_d.batch_done = in_w.batch_end;
          state_d          = S_OUT;
          case (in_w.command)
            CmdWrite: begin
              if (id_in_table) begin
                exp_we    = 1'b1;
                exp_waddr = ExpAw'(in_w.exposure_id);
                exp_wdata = new_entry;
              end
            end
            CmdAdd: begin
              if (add_ok) begin
                exp_re  = 1'b1;
                state_d = S_LOOK;
              end
            end
            CmdRead: begin
              if (node_ok) begin
                node_re = 1'b1;
                state_d = S_RD;
              end
            end
            default: begin
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_LOOK: begin
        node_re    = exp_rd.mapped && (32'(exp_rd.node) < NODES);
        node_raddr = NodeAw'(exp_rd.node);
        state_d    = S_ACC;
      end
      S_ACC: begin
        res_d.entry_valid   = (entry_q.value != '0) && entry_q.mapped &&
                              (item_q.peril == entry_q.peril);
        res_d.mapped_flag   = entry_q.mapped;
        res_d.mapped_node   = entry_q.mapped ? entry_q.node : '0;
        res_d.exposure_loss = loss;
        if (acc_hit) begin
          node_we             = 1'b1;
          node_waddr          = NodeAw'(entry_q.node);
          node_wdata          = node_sum;
          res_d.overflow_flag = loss_sum[AccW] || value_sum[AccW];
        end
        state_d = S_OUT;
      end
      S_RD: begin
        res_d.node_loss_total  = node_rd.loss_total;
        res_d.node_value_total = node_rd.value_total;
        if (item_q.clear_after_read) begin
          node_we    = 1'b1;
          node_waddr = NodeAw'(item_q.node_index);
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_acc) begin
      item_q <= in_w;
    end
    if (state_q == S_LOOK) begin
      entry_q <= exp_rd;
      prod_q  <= ProdW'(exp_rd.value) * ProdW'(item_q.loss_ratio);
    end
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule
